// ===== hdl/frc_pkg.sv =====
// shared types, constants and crc helper for the framed receive checker
package frc_pkg;

    localparam logic [7:0]  SYNC_HIGH    = 8'hE1;
    localparam logic [7:0]  SYNC_LOW     = 8'hC3;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] HEADER_BYTES = 16'd6;

    localparam logic [1:0] CFG_SLOT0_ADDR = 2'd0;
    localparam logic [1:0] CFG_SLOT0_EN   = 2'd1;
    localparam logic [1:0] CFG_SLOT1_ADDR = 2'd2;
    localparam logic [1:0] CFG_SLOT1_EN   = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_BODY   = 3'd3,
        PH_CRC_HI = 3'd4,
        PH_CRC_LO = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CRC_ERR   = 3'd1,
        ST_ADDR_ERR  = 3'd2,
        ST_TOO_SHORT = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] slot0_address;
        logic       slot0_enable;
        logic [7:0] slot1_address;
        logic       slot1_enable;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        t_status     status;
        logic [15:0] frame_number;
        logic [7:0]  frame_kind;
        logic [7:0]  command_code;
        logic [7:0]  sub_command;
        logic        slot_index;
        logic [6:0]  payload_length;
    } t_result;

    // reflected crc16, one byte folded in lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

// ===== hdl/framed_rx_crc16_checker.sv =====
// an accepted byte is registered, then parsed on advance; its result is registered in the result slot
// throughput: one byte per cycle unless a full result slot stalls; crc16 and state step in the same cycle
// the input register frees whenever its byte moves into the parser or the result slot is free
// results are one per payload byte and one verdict per frame; other bytes give none
// reset (synchronous, active low) clears the slot registers, the hunt state and both valid flags
module framed_rx_crc16_checker
    import frc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 128
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received byte request
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    // result request
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_status,
    output logic [15:0] o_frame_number,
    output logic [7:0]  o_frame_kind,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_sub_command,
    output logic        o_slot_index,
    output logic [6:0]  o_payload_length,
    // slot configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg    r_cfg;
    logic    in_valid;
    logic [7:0] in_byte;
    logic    advance;
    logic    has_result;
    t_result parse_result;
    t_result out_result;

    // slot registers; the user must write them only while the receiver is quiet, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLOT0_ADDR: r_cfg.slot0_address <= i_cfg_data;
                CFG_SLOT0_EN:   r_cfg.slot0_enable  <= i_cfg_data[0];
                CFG_SLOT1_ADDR: r_cfg.slot1_address <= i_cfg_data;
                CFG_SLOT1_EN:   r_cfg.slot1_enable  <= i_cfg_data[0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    // a held byte moves on when the result slot is empty or being drained;
    // bytes that give no result still wait, which keeps result order simple
    assign advance = in_valid && (!o_valid || i_ready);

    frc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_ready   (o_ready),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_rx_byte (in_byte)
    );

    // parser steps its state only on advance
    frc_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (advance),
        .i_rx_byte    (in_byte),
        .i_cfg        (r_cfg),
        .o_has_result (has_result),
        .o_result     (parse_result)
    );

    frc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (has_result),
        .i_result (parse_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    // unpack result fields onto ports
    assign o_kind           = out_result.kind;
    assign o_data_byte      = out_result.data_byte;
    assign o_status         = out_result.status;
    assign o_frame_number   = out_result.frame_number;
    assign o_frame_kind     = out_result.frame_kind;
    assign o_command_code   = out_result.command_code;
    assign o_sub_command    = out_result.sub_command;
    assign o_slot_index     = out_result.slot_index;
    assign o_payload_length = out_result.payload_length;

`ifndef NO_ASSERTIONS
    // payload results carry nothing but the byte
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> (o_status == ST_OK && o_frame_number == 16'h0000
            && o_payload_length == 7'd0 && o_slot_index == 1'b0))
        else $error("payload result carries header fields");

    // slot index only set on a good frame
    a_slot_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_slot_index) |-> (o_kind && o_status == ST_OK))
        else $error("slot index set on a failed frame");

    // length verdicts come without header fields
    a_len_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_TOO_SHORT || o_status == ST_TOO_LONG))
            |-> (o_kind && o_frame_number == 16'h0000 && o_payload_length == 7'd0))
        else $error("length verdict carries header fields");

    // a parser result is only produced when the result slot can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        has_result |-> (!o_valid || i_ready))
        else $error("result register overwritten");
`endif

endmodule

// ===== hdl/frc_in_stage.sv =====
// input register holding one received byte until the parser takes it
module frc_in_stage
    import frc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_ready,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_rx_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready   = !r_valid || i_advance;
    assign o_valid   = r_valid;
    assign o_rx_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

// ===== hdl/frc_parser.sv =====
// frame state machine: sync hunt, length, header capture, crc and verdict
module frc_parser
    import frc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 128
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_has_result,
    output t_result    o_result
);

    localparam int IDX_W = $clog2(MAX_FRAME_BYTES);

    t_phase          r_phase, n_phase;
    logic [7:0]      r_prev, n_prev;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [15:0]     r_len, n_len;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_crc_hi, n_crc_hi;
    logic [15:0]     r_number, n_number;
    logic [7:0]      r_address, n_address;
    logic [7:0]      r_type, n_type;
    logic [7:0]      r_command, n_command;
    logic [7:0]      r_sub, n_sub;

    logic [15:0] len_full;
    logic [16:0] len_plus_hdr;
    logic [15:0] crc_step;
    logic [15:0] crc_recv;

    assign len_full     = {r_len[15:8], i_rx_byte};
    assign len_plus_hdr = {1'b0, len_full} + {1'b0, HEADER_BYTES};
    assign crc_step     = crc16_byte(r_crc, i_rx_byte);
    assign crc_recv     = {r_crc_hi, i_rx_byte};

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_prev    = r_prev;
        n_idx     = r_idx;
        n_len     = r_len;
        n_crc     = r_crc;
        n_crc_hi  = r_crc_hi;
        n_number  = r_number;
        n_address = r_address;
        n_type    = r_type;
        n_command = r_command;
        n_sub     = r_sub;
        case (r_phase)
            PH_LEN_HI: begin
                n_len   = {i_rx_byte, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = len_full;
                if (len_full < HEADER_BYTES
                        || len_plus_hdr > 17'(MAX_FRAME_BYTES)) begin
                    n_phase = PH_HUNT;
                    n_prev  = 8'h00;
                end else begin
                    n_idx   = '0;
                    n_crc   = 16'h0000;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_crc = crc_step;
                if (r_idx == IDX_W'(0)) begin
                    n_number = {i_rx_byte, 8'h00};
                end else if (r_idx == IDX_W'(1)) begin
                    n_number = {r_number[15:8], i_rx_byte};
                end else if (r_idx == IDX_W'(2)) begin
                    n_address = i_rx_byte;
                end else if (r_idx == IDX_W'(3)) begin
                    n_type = i_rx_byte;
                end else if (r_idx == IDX_W'(4)) begin
                    n_command = i_rx_byte;
                end else if (r_idx == IDX_W'(5)) begin
                    n_sub = i_rx_byte;
                end
                n_idx = r_idx + IDX_W'(1);
                if (16'(r_idx) + 16'd1 >= r_len) begin
                    n_phase = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                n_crc_hi = i_rx_byte;
                n_phase  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                n_phase = PH_HUNT;
                n_prev  = 8'h00;
            end
            default: begin
                if (r_prev == SYNC_HIGH && i_rx_byte == SYNC_LOW) begin
                    n_phase = PH_LEN_HI;
                    n_prev  = 8'h00;
                end else begin
                    n_phase = PH_HUNT;
                    n_prev  = i_rx_byte;
                end
            end
        endcase
    end

    // result for this byte
    always_comb begin
        o_has_result = 1'b0;
        o_result     = '0;
        case (r_phase)
            PH_LEN_LO: begin
                if (len_full < HEADER_BYTES) begin
                    o_has_result    = i_valid;
                    o_result.kind   = 1'b1;
                    o_result.status = ST_TOO_SHORT;
                end else if (len_plus_hdr > 17'(MAX_FRAME_BYTES)) begin
                    o_has_result    = i_valid;
                    o_result.kind   = 1'b1;
                    o_result.status = ST_TOO_LONG;
                end
            end
            PH_BODY: begin
                if (r_idx > IDX_W'(5)) begin
                    o_has_result       = i_valid;
                    o_result.data_byte = i_rx_byte;
                end
            end
            PH_CRC_LO: begin
                o_has_result            = i_valid;
                o_result.kind           = 1'b1;
                o_result.frame_number   = r_number;
                o_result.frame_kind     = r_type;
                o_result.command_code   = r_command;
                o_result.sub_command    = r_sub;
                o_result.payload_length = 7'(r_len - HEADER_BYTES);
                if (crc_recv != r_crc) begin
                    o_result.status = ST_CRC_ERR;
                end else if (i_cfg.slot0_enable && r_address == i_cfg.slot0_address) begin
                    o_result.status = ST_OK;
                end else if (i_cfg.slot1_enable && r_address == i_cfg.slot1_address) begin
                    o_result.status     = ST_OK;
                    o_result.slot_index = 1'b1;
                end else begin
                    o_result.status = ST_ADDR_ERR;
                end
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_prev  <= 8'h00;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_idx     <= n_idx;
            r_len     <= n_len;
            r_crc     <= n_crc;
            r_crc_hi  <= n_crc_hi;
            r_number  <= n_number;
            r_address <= n_address;
            r_type    <= n_type;
            r_command <= n_command;
            r_sub     <= n_sub;
        end
    end

endmodule

// ===== hdl/frc_out_stage.sv =====
// result register toward the downstream consumer
module frc_out_stage
    import frc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
